// File: hdl/nclp_pkg.sv
// Package for the numeric and character literal parser.
// Holds the phase enum, kind and status codes, character constants and the
// word types passed between the front end and the back end. No dependencies.
package nclp_pkg;

	// queue depths
	localparam int unsigned IN_QUEUE_DEPTH  = 2;
	localparam int unsigned OUT_QUEUE_DEPTH = 2;

	// magnitude register, saturating
	localparam int unsigned MAG_W = 33;
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [MAG_W-1:0] LIMIT_POS = 33'h0_FFFF_FFFF;
	localparam logic [MAG_W-1:0] LIMIT_NEG = 33'h0_8000_0000;
	localparam int unsigned CHAR_POS_MAX = 7;

	// parse phase
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_SIGN   = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_CHAR   = 3'd4
	} phase_t;

	// literal kind codes
	localparam logic [1:0] KIND_DEC = 2'd0;
	localparam logic [1:0] KIND_HEX = 2'd1;
	localparam logic [1:0] KIND_BIN = 2'd2;
	localparam logic [1:0] KIND_CHR = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// characters
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_V   = 8'h76;
	localparam logic [7:0] CH_LO_X   = 8'h78;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;

	// classified input word, front end to back end
	typedef struct packed {
		logic [7:0] chr;
		logic       last;
		logic       is_plus;
		logic       is_minus;
		logic       is_quote;
		logic       is_bslash;
		logic       is_x;
		logic       is_b;
		logic       is_zero;
		logic       dec_ok;
		logic       hex_ok;
		logic       bin_ok;
		logic [3:0] digit;
		logic       esc_ok;
		logic [7:0] esc_val;
	} class_t;

	// result word
	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  kind;
		logic [1:0]  status;
	} result_t;

endpackage

// File: hdl/nclp_front.sv
// Front end: classifies each incoming character and queues the classified word.
// Depends on nclp_pkg.
module nclp_front import nclp_pkg::*; #(
	parameter int unsigned DEPTH = IN_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] token_char,
	input  logic       last,
	output logic       cls_valid,
	output class_t     cls,
	input  logic       cls_take
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	class_t             queue_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	class_t             cls_n;
	logic               push_ok;

	// escape table
	function automatic logic [8:0] escape_lookup(input logic [7:0] c);
		logic [8:0] r;
		r = 9'd0;
		case (c)
			CH_QUOTE:  r = {1'b1, 8'd39};
			CH_DQUOTE: r = {1'b1, 8'd34};
			CH_QMARK:  r = {1'b1, 8'd63};
			CH_BSLASH: r = {1'b1, 8'd92};
			CH_LO_A:   r = {1'b1, 8'd7};
			CH_LO_B:   r = {1'b1, 8'd8};
			CH_LO_F:   r = {1'b1, 8'd12};
			CH_LO_N:   r = {1'b1, 8'd10};
			CH_LO_R:   r = {1'b1, 8'd13};
			CH_LO_T:   r = {1'b1, 8'd9};
			CH_LO_V:   r = {1'b1, 8'd11};
			CH_ZERO:   r = {1'b1, 8'd0};
			default:   r = 9'd0;
		endcase
		return r;
	endfunction

	// classify the character
	always_comb begin
		logic [8:0] esc;
		logic       lo_hex;
		logic       up_hex;
		esc    = escape_lookup(token_char);
		lo_hex = (token_char >= CH_LO_A) && (token_char <= CH_LO_F);
		up_hex = (token_char >= CH_UP_A) && (token_char <= CH_UP_F);
		cls_n.chr       = token_char;
		cls_n.last      = last;
		cls_n.is_plus   = (token_char == CH_PLUS);
		cls_n.is_minus  = (token_char == CH_MINUS);
		cls_n.is_quote  = (token_char == CH_QUOTE);
		cls_n.is_bslash = (token_char == CH_BSLASH);
		cls_n.is_x      = (token_char == CH_LO_X);
		cls_n.is_b      = (token_char == CH_LO_B);
		cls_n.is_zero   = (token_char == CH_ZERO);
		cls_n.dec_ok    = (token_char >= CH_ZERO) && (token_char <= CH_NINE);
		cls_n.hex_ok    = cls_n.dec_ok || lo_hex || up_hex;
		cls_n.bin_ok    = (token_char == CH_ZERO) || (token_char == CH_ONE);
		if (lo_hex)
			cls_n.digit = 4'(token_char - CH_LO_A + 8'd10);
		else if (up_hex)
			cls_n.digit = 4'(token_char - CH_UP_A + 8'd10);
		else
			cls_n.digit = 4'(token_char - CH_ZERO);
		cls_n.esc_ok  = esc[8];
		cls_n.esc_val = esc[7:0];
	end

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign push_ok   = push && !full;
	assign cls_valid = (cnt_q != '0);
	assign cls       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push_ok)
			queue_q[wr_ptr_q] <= cls_n;
	end

	// queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (cls_take)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push_ok, cls_take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// checks
	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("input queue count beyond depth");
	ap_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cls_take |-> cls_valid)
		else $error("word taken from empty input queue");
	ap_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !cls_take) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("input queue count did not grow on write");

endmodule

// File: hdl/nclp_back.sv
// Back end: runs the literal parse state on classified words and queues results.
// Depends on nclp_pkg.
module nclp_back import nclp_pkg::*; #(
	parameter int unsigned DEPTH = OUT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cls_valid,
	input  class_t      cls,
	output logic        cls_take,
	input  logic        pop,
	output logic        empty,
	output logic [31:0] value,
	output logic [1:0]  kind,
	output logic [1:0]  status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// parse state
	phase_t           ph_q, ph_n;
	logic             neg_q, neg_n;
	logic [1:0]       rk_q, rk_n;
	logic [MAG_W-1:0] mag_q, mag_n;
	logic             ovf_q, ovf_n;
	logic             bad_q, bad_n;
	logic             seen_q, seen_n;
	logic [2:0]       pos_q, pos_n;
	logic [7:0]       held_q, held_n;
	logic             char_done;

	// digit accumulate
	logic             d_ok;
	logic [36:0]      mul;
	logic [37:0]      sum;
	logic             add_ovf;
	logic [MAG_W-1:0] add_mag;

	// result queue
	result_t          res_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	result_t          res_n;
	logic             res_push;
	logic             pop_ok;
	logic             out_full;

	assign out_full = (cnt_q == CNT_W'(DEPTH));
	assign cls_take = cls_valid && (!out_full || !cls.last);
	assign res_push = cls_take && cls.last;
	assign empty    = (cnt_q == '0);
	assign pop_ok   = pop && !empty;
	assign value    = res_q[rd_ptr_q].value;
	assign kind     = res_q[rd_ptr_q].kind;
	assign status   = res_q[rd_ptr_q].status;

	// multiply by radix and add the digit, saturating
	always_comb begin
		case (rk_q)
			KIND_HEX: mul = {mag_q, 4'b0};
			KIND_BIN: mul = {3'b0, mag_q, 1'b0};
			default:  mul = {1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0};
		endcase
		sum     = {1'b0, mul} + {34'd0, cls.digit};
		add_ovf = ovf_q || (sum[37:MAG_W] != '0);
		add_mag = add_ovf ? MAG_MAX : sum[MAG_W-1:0];
		case (rk_q)
			KIND_HEX: d_ok = cls.hex_ok;
			KIND_BIN: d_ok = cls.bin_ok;
			default:  d_ok = cls.dec_ok;
		endcase
	end

	// next parse state
	always_comb begin
		ph_n      = ph_q;
		neg_n     = neg_q;
		rk_n      = rk_q;
		mag_n     = mag_q;
		ovf_n     = ovf_q;
		bad_n     = bad_q;
		seen_n    = seen_q;
		pos_n     = pos_q;
		held_n    = held_q;
		char_done = 1'b0;
		if (!bad_q) begin
			case (ph_q)
				PH_START, PH_SIGN: begin
					if (ph_q == PH_START && (cls.is_plus || cls.is_minus)) begin
						neg_n = cls.is_minus;
						ph_n  = PH_SIGN;
					end else if (ph_q == PH_START && cls.is_quote) begin
						ph_n = PH_CHAR;
						rk_n = KIND_CHR;
					end else if (cls.dec_ok) begin
						ph_n   = cls.is_zero ? PH_ZERO : PH_DIGITS;
						rk_n   = KIND_DEC;
						mag_n  = add_mag;
						ovf_n  = add_ovf;
						seen_n = 1'b1;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_ZERO: begin
					if (cls.is_x) begin
						rk_n   = KIND_HEX;
						seen_n = 1'b0;
						ph_n   = PH_DIGITS;
					end else if (cls.is_b) begin
						rk_n   = KIND_BIN;
						seen_n = 1'b0;
						ph_n   = PH_DIGITS;
					end else if (cls.dec_ok) begin
						ph_n   = PH_DIGITS;
						mag_n  = add_mag;
						ovf_n  = add_ovf;
						seen_n = 1'b1;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (d_ok) begin
						mag_n  = add_mag;
						ovf_n  = add_ovf;
						seen_n = 1'b1;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_CHAR: begin
					if (pos_q != 3'(CHAR_POS_MAX))
						pos_n = pos_q + 1'b1;
					case (pos_n)
						3'd1: begin
							held_n = cls.chr;
							if (cls.last)
								bad_n = 1'b1;
						end
						3'd2: begin
							if (cls.last) begin
								if (cls.is_quote && held_q != CH_BSLASH)
									char_done = 1'b1;
								else
									bad_n = 1'b1;
							end else if (held_q == CH_BSLASH && cls.esc_ok) begin
								held_n = cls.esc_val;
							end else begin
								bad_n = 1'b1;
							end
						end
						3'd3: begin
							if (cls.last && cls.is_quote)
								char_done = 1'b1;
							else
								bad_n = 1'b1;
						end
						default: bad_n = 1'b1;
					endcase
				end
				default: bad_n = 1'b1;
			endcase
		end
	end

	// result of a closing character
	always_comb begin
		res_n.value  = 32'd0;
		res_n.kind   = KIND_DEC;
		res_n.status = ST_BAD;
		if (!bad_n) begin
			if (ph_n == PH_CHAR) begin
				if (char_done) begin
					res_n.value  = {{24{held_n[7]}}, held_n};
					res_n.kind   = KIND_CHR;
					res_n.status = ST_OK;
				end
			end else if ((ph_n == PH_ZERO || ph_n == PH_DIGITS) && seen_n) begin
				res_n.kind = rk_n;
				if (ovf_n || mag_n > (neg_n ? LIMIT_NEG : LIMIT_POS)) begin
					res_n.status = ST_RANGE;
				end else begin
					res_n.value  = neg_n ? (32'd0 - mag_n[31:0]) : mag_n[31:0];
					res_n.status = ST_OK;
				end
			end
		end
	end

	// parse state registers; cleared after each token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_START;
			neg_q  <= 1'b0;
			rk_q   <= KIND_DEC;
			mag_q  <= '0;
			ovf_q  <= 1'b0;
			bad_q  <= 1'b0;
			seen_q <= 1'b0;
			pos_q  <= '0;
			held_q <= '0;
		end else if (cls_take) begin
			if (cls.last) begin
				ph_q   <= PH_START;
				neg_q  <= 1'b0;
				rk_q   <= KIND_DEC;
				mag_q  <= '0;
				ovf_q  <= 1'b0;
				bad_q  <= 1'b0;
				seen_q <= 1'b0;
				pos_q  <= '0;
				held_q <= '0;
			end else begin
				ph_q   <= ph_n;
				neg_q  <= neg_n;
				rk_q   <= rk_n;
				mag_q  <= mag_n;
				ovf_q  <= ovf_n;
				bad_q  <= bad_n;
				seen_q <= seen_n;
				pos_q  <= pos_n;
				held_q <= held_n;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (res_push)
			res_q[wr_ptr_q] <= res_n;
	end

	// result queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_ok)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({res_push, pop_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// checks
	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue count beyond depth");
	ap_token_reset: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (ph_q == PH_START) && !bad_q && (mag_q == '0) && !ovf_q)
		else $error("parse state not cleared after closing character");
	ap_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_n.status == ST_OK) || (res_n.value == 32'd0))
		else $error("non-zero word with error status");
	ap_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_push && !pop_ok) |=> $stable(cnt_q))
		else $error("result queue count moved without a write or read");

endmodule

// File: hdl/numeric_char_literal_parser.sv
// A result enters the result queue on the edge that takes the closing character.
// Throughput: one character per cycle unless stalled; each digit's shift-add is combinational.
// The block stalls only when the result queue is full and a closing character waits.
// Reset (arst_n low, asynchronous): both queues empty, parse state at start of token.
// Top level: front end, classified-word queue, parse back end and result queue.
// Depends on nclp_pkg, nclp_front, nclp_back.
module numeric_char_literal_parser import nclp_pkg::*; #(
	parameter int unsigned IN_DEPTH  = IN_QUEUE_DEPTH,
	parameter int unsigned OUT_DEPTH = OUT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  token_char,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] value,
	output logic [1:0]  kind,
	output logic [1:0]  status
);

	logic   cls_valid;
	logic   cls_take;
	class_t cls;

	// classify and queue characters
	nclp_front #(
		.DEPTH (IN_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.token_char (token_char),
		.last       (last),
		.cls_valid  (cls_valid),
		.cls        (cls),
		.cls_take   (cls_take)
	);

	// parse and queue results
	nclp_back #(
		.DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_take  (cls_take),
		.pop       (pop),
		.empty     (empty),
		.value     (value),
		.kind      (kind),
		.status    (status)
	);

endmodule

// File: tb/numeric_char_literal_parser_test.sv
// Self-checking testbench for numeric_char_literal_parser: streams token characters through
// the push/full queue, predicts each literal's word and checks what comes out at pop/empty.
// Depends on nclp_pkg and the parser RTL; stands alone otherwise.
module numeric_char_literal_parser_test;
	import nclp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_CHARS = 550;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [7:0]  CASE_GAP     = 8'h20;

	typedef struct {
		logic [7:0] chr;
		logic       lst;
		bit         drain;
	} char_item_t;

	typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  token_char = 8'h00;
	logic        last = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] value;
	logic [1:0]  kind;
	logic [1:0]  status;

	numeric_char_literal_parser DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .token_char(token_char), .last(last),
		.empty(empty), .pop(pop), .value(value), .kind(kind), .status(status)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// characters still to be sent, and literal words still to come out
	char_item_t  char_backlog[$];
	result_t     literal_results_due[$];
	logic [7:0]  tok[$];

	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned result_count = 0;
	int unsigned token_count = 0;
	int unsigned char_count = 0;
	int unsigned drain_count = 0;
	int unsigned status_hits[3] = '{0, 0, 0};
	int unsigned kind_hits[4] = '{0, 0, 0, 0};

	// parser state mirror
	phase_t           ph;
	logic             neg;
	logic [1:0]       rk;
	logic [MAG_W-1:0] mag;
	logic             ovf;
	logic             bad;
	logic             seen;
	logic [2:0]       cpos;
	logic [7:0]       held;

	function automatic void clear_parse();
		ph = PH_START;
		neg = 1'b0;
		rk = KIND_DEC;
		mag = '0;
		ovf = 1'b0;
		bad = 1'b0;
		seen = 1'b0;
		cpos = '0;
		held = '0;
	endfunction

	// digit weight in the current radix, -1 if the character is no digit of it
	function automatic int digit_of(logic [7:0] c, logic [1:0] k);
		if (k == KIND_BIN)
			return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : -1;
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (k == KIND_HEX) begin
			if (c >= CH_LO_A && c <= CH_LO_F)
				return int'(c - CH_LO_A) + 10;
			if (c >= CH_UP_A && c <= CH_UP_F)
				return int'(c - CH_UP_A) + 10;
		end
		return -1;
	endfunction

	// decoded byte of a backslash escape, -1 outside the allowed set
	function automatic int escape_code(logic [7:0] c);
		case (c)
			CH_QUOTE:  return 39;
			CH_DQUOTE: return 34;
			CH_QMARK:  return 63;
			CH_BSLASH: return 92;
			CH_LO_A:   return 7;
			CH_LO_B:   return 8;
			CH_LO_F:   return 12;
			CH_LO_N:   return 10;
			CH_LO_R:   return 13;
			CH_LO_T:   return 9;
			CH_LO_V:   return 11;
			CH_ZERO:   return 0;
			default:   return -1;
		endcase
	endfunction

	// shift-add with a saturating, sticky magnitude
	function automatic void accumulate(int d);
		logic [39:0] nxt;
		logic [39:0] base;
		base = (rk == KIND_HEX) ? 40'd16 : (rk == KIND_BIN) ? 40'd2 : 40'd10;
		nxt = {7'd0, mag} * base + 40'(d);
		if (ovf || nxt > {7'd0, MAG_MAX}) begin
			ovf = 1'b1;
			mag = MAG_MAX;
		end else begin
			mag = nxt[MAG_W-1:0];
		end
		seen = 1'b1;
	endfunction

	// first character of the number body, after any sign
	function automatic void body_start(logic [7:0] c);
		if (c == CH_ZERO) begin
			ph = PH_ZERO;
			rk = KIND_DEC;
			accumulate(0);
		end else if (c >= CH_ONE && c <= CH_NINE) begin
			ph = PH_DIGITS;
			rk = KIND_DEC;
			accumulate(int'(c - CH_ZERO));
		end else begin
			bad = 1'b1;
		end
	endfunction

	// predict one accepted character; a closing character queues the literal's word
	function automatic void parse_char(logic [7:0] c, logic lst);
		logic             done;
		int               d;
		result_t          r;
		logic [MAG_W-1:0] lim;
		done = 1'b0;
		if (!bad) begin
			case (ph)
				PH_START: begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						neg = (c == CH_MINUS);
						ph = PH_SIGN;
					end else if (c == CH_QUOTE) begin
						ph = PH_CHAR;
						rk = KIND_CHR;
					end else begin
						body_start(c);
					end
				end
				PH_SIGN: body_start(c);
				PH_ZERO: begin
					if (c == CH_LO_X) begin
						rk = KIND_HEX;
						seen = 1'b0;
						ph = PH_DIGITS;
					end else if (c == CH_LO_B) begin
						rk = KIND_BIN;
						seen = 1'b0;
						ph = PH_DIGITS;
					end else if (c >= CH_ZERO && c <= CH_NINE) begin
						ph = PH_DIGITS;
						accumulate(int'(c - CH_ZERO));
					end else begin
						bad = 1'b1;
					end
				end
				PH_DIGITS: begin
					d = digit_of(c, rk);
					if (d < 0)
						bad = 1'b1;
					else
						accumulate(d);
				end
				PH_CHAR: begin
					if (cpos < 3'(CHAR_POS_MAX))
						cpos++;
					if (cpos == 3'd1) begin
						held = c;
						if (lst)
							bad = 1'b1;
					end else if (cpos == 3'd2) begin
						if (lst) begin
							if (c == CH_QUOTE && held != CH_BSLASH)
								done = 1'b1;
							else
								bad = 1'b1;
						end else if (held == CH_BSLASH) begin
							d = escape_code(c);
							if (d < 0)
								bad = 1'b1;
							else
								held = 8'(d);
						end else begin
							bad = 1'b1;
						end
					end else if (cpos == 3'd3 && lst && c == CH_QUOTE) begin
						done = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
		end
		if (lst) begin
			r.value = '0;
			r.kind = KIND_DEC;
			r.status = ST_BAD;
			if (!bad) begin
				if (ph == PH_CHAR) begin
					if (done) begin
						r.value = {{24{held[7]}}, held};
						r.kind = KIND_CHR;
						r.status = ST_OK;
					end
				end else if ((ph == PH_ZERO || ph == PH_DIGITS) && seen) begin
					lim = neg ? LIMIT_NEG : LIMIT_POS;
					r.kind = rk;
					if (ovf || mag > lim) begin
						r.status = ST_RANGE;
					end else begin
						r.value = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
						r.status = ST_OK;
					end
				end
			end
			literal_results_due.insert(literal_results_due.size(), r);
			clear_parse();
		end
	endfunction

	// token building
	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			tok.insert(tok.size(), s[i]);
	endfunction

	function automatic void send_token(bit drain);
		char_item_t item;
		for (int i = 0; i < tok.size(); i++) begin
			item.chr = tok[i];
			item.lst = (i == tok.size() - 1);
			item.drain = drain && i == 0;
			char_backlog.insert(char_backlog.size(), item);
		end
		char_count += tok.size();
		token_count++;
		tok.delete();
	endfunction

	function automatic void token(string s);
		put_str(s);
		send_token(1'b0);
	endfunction

	// optional sign, a few leading zeros now and then
	function automatic string dress_number(string body, string prefix);
		string s;
		s = body;
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) s = {"0", s};
		s = {prefix, s};
		case ($urandom_range(0, 7))
			0, 1:    s = {"-", s};
			2:       s = {"+", s};
			default: ;
		endcase
		return s;
	endfunction

	// a well-formed literal of the given form: 0 dec, 1 hex, 2 bin, 3 char
	function automatic void build_valid(int form);
		longint unsigned m;
		string           s;
		int              w;
		logic [7:0]      b;
		case (form)
			0: begin
				case ($urandom_range(0, 5))
					0:       m = 64'($urandom_range(0, 999));
					1:       m = 64'($urandom);
					2:       m = 64'hFFFF_FFFF - 2 + $urandom_range(0, 4);
					3:       m = 64'h8000_0000 - 2 + $urandom_range(0, 4);
					4:       m = {$urandom, $urandom};
					default: m = 64'($urandom_range(0, 9));
				endcase
				put_str(dress_number($sformatf("%0d", m), ""));
			end
			1: begin
				case ($urandom_range(0, 3))
					0:       m = 64'($urandom);
					1:       m = 64'($urandom_range(0, 255));
					2:       m = {$urandom_range(0, 255), $urandom};
					default: m = 64'hFFFF_FFFF - 1 + $urandom_range(0, 2);
				endcase
				s = $sformatf("%0h", m);
				for (int i = 0; i < s.len(); i++)
					if (s[i] >= CH_LO_A && s[i] <= CH_LO_F && $urandom_range(0, 1))
						s[i] = s[i] - CASE_GAP;
				put_str(dress_number(s, ""));
				// prefix goes after the sign
				if (tok[0] == CH_PLUS || tok[0] == CH_MINUS) begin
					tok.insert(1, CH_LO_X);
					tok.insert(1, CH_ZERO);
				end else begin
					tok.push_front(CH_LO_X);
					tok.push_front(CH_ZERO);
				end
			end
			2: begin
				w = $urandom_range(1, 34);
				m = {$urandom, $urandom} & ((64'd1 << w) - 1);
				put_str(dress_number($sformatf("%0b", m), ""));
				if (tok[0] == CH_PLUS || tok[0] == CH_MINUS) begin
					tok.insert(1, CH_LO_B);
					tok.insert(1, CH_ZERO);
				end else begin
					tok.push_front(CH_LO_B);
					tok.push_front(CH_ZERO);
				end
			end
			default: begin
				tok.insert(tok.size(), CH_QUOTE);
				if ($urandom_range(0, 1)) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_BSLASH)
						b = CH_QUOTE;
					tok.insert(tok.size(), b);
				end else begin
					tok.insert(tok.size(), CH_BSLASH);
					case ($urandom_range(0, 11))
						0:       b = CH_QUOTE;
						1:       b = CH_DQUOTE;
						2:       b = CH_QMARK;
						3:       b = CH_BSLASH;
						4:       b = CH_LO_A;
						5:       b = CH_LO_B;
						6:       b = CH_LO_F;
						7:       b = CH_LO_N;
						8:       b = CH_LO_R;
						9:       b = CH_LO_T;
						10:      b = CH_LO_V;
						default: b = CH_ZERO;
					endcase
					tok.insert(tok.size(), b);
				end
				tok.insert(tok.size(), CH_QUOTE);
			end
		endcase
	endfunction

	// one random token: mostly well formed, some corrupted, some noise
	function automatic void random_token(bit drain);
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			build_valid(0);
		end else if (pick < 40) begin
			build_valid(1);
		end else if (pick < 55) begin
			build_valid(2);
		end else if (pick < 75) begin
			build_valid(3);
		end else if (pick < 88) begin
			build_valid($urandom_range(0, 3));
			idx = $urandom_range(0, tok.size() - 1);
			case ($urandom_range(0, 2))
				0: tok[idx] = 8'($urandom_range(0, 255));
				1: if (tok.size() > 1) tok.delete(tok.size() - 1);
				default: tok.insert(tok.size(), 8'($urandom_range(0, 255)));
			endcase
		end else begin
			repeat ($urandom_range(1, 6)) tok.insert(tok.size(), 8'($urandom_range(0, 255)));
		end
		send_token(drain);
	endfunction

	// sender: bursts with gaps, holds a drain-marked word until the parser is empty
	int         burst_left = 1;
	int         gap_left = 0;
	logic       in_taken = 1'b0;
	char_item_t next_item;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!push || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (char_backlog.size() == 0) begin
					push <= 1'b0;
				end else if (char_backlog[0].drain && literal_results_due.size() != 0) begin
					push <= 1'b0;
				end else begin
					next_item = char_backlog.pop_front();
					if (next_item.drain)
						drain_count++;
					push <= 1'b1;
					token_char <= next_item.chr;
					last <= next_item.lst;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// receiver: picks a new stall pattern whenever the current one runs out
	rx_mode_t    rx_mode = RX_FLOW;
	int          rx_left = 0;
	logic [3:0]  rx_phase = '0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 64);
			end
			rx_left--;
			rx_phase++;
			case (rx_mode)
				RX_FLOW:   pop <= 1'b1;
				RX_COIN:   pop <= 1'($urandom_range(0, 1));
				RX_SPARSE: pop <= ($urandom_range(0, 5) == 0);
				default:   pop <= rx_phase[1];
			endcase
		end
	end

	// monitor: check popped words against the oldest prediction, then predict new ones
	result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				result_count++;
				if (literal_results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word %0d: value %h kind %0d status %0d",
							result_count, value, kind, status);
				end else begin
					want = literal_results_due.pop_front();
					if ($size(status_hits) > want.status)
						status_hits[want.status]++;
					if (want.status == ST_OK)
						kind_hits[want.kind]++;
					if (value !== want.value || kind !== want.kind || status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("word %0d mismatch: value %h/%h kind %0d/%0d status %0d/%0d (exp/got)",
								result_count, want.value, value, want.kind, kind,
								want.status, status);
					end
				end
			end
			if (push && !full)
				parse_char(token_char, last);
			in_taken <= push && !full;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d words outstanding",
				cycle_count, literal_results_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		clear_parse();

		// directed: range edges, prefixes, signs, escapes and malformed tokens
		token("0");
		token("4294967295");
		token("4294967296");
		token("-2147483648");
		token("-2147483649");
		token("+7");
		token("007");
		token("99999999999999999999");
		token("0xFFFFFFFF");
		token("0xdeadBEEF");
		token("0x100000000");
		token("0b1011");
		token("0x");
		token("0b");
		token("-");
		token("'");
		token("0X1");
		token("0B1");
		token("+-1");
		token("1z23");
		put_str("-'a'");
		send_token(1'b1);
		token("'a'");
		token("'\\n'");
		token("'\\0'");
		token("'\\\\'");
		token("'\\''");
		token("'\\'");
		token("'\\q'");
		token("''");
		token("'ab'");
		tok = '{CH_QUOTE, 8'hFF, CH_QUOTE};
		send_token(1'b0);
		tok = '{CH_QUOTE, 8'h80, CH_QUOTE};
		send_token(1'b0);

		// random part, with an occasional wait for the parser to empty
		random_token(1'b1);
		while (char_backlog.size() < RANDOM_CHARS)
			random_token($urandom_range(0, 39) == 0);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (char_backlog.size() != 0 || push || literal_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (literal_results_due.size() != 0)
			fail_count++;
		$display("covered %0d tokens in %0d characters over %0d cycles, %0d drain pauses",
			token_count, char_count, cycle_count, drain_count);
		$display("words: ok %0d (dec %0d hex %0d bin %0d char %0d), bad %0d, range %0d, failures %0d",
			status_hits[0], kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
			status_hits[1], status_hits[2], fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: numeric_char_literal_parser.f
hdl/nclp_pkg.sv
hdl/nclp_front.sv
hdl/nclp_back.sv
hdl/numeric_char_literal_parser.sv
tb/numeric_char_literal_parser_test.sv
